>>> hdl/ndisp_pkg.sv
// Shared types, codes and denomination tables for the note dispenser.
package ndisp_pkg;

    localparam int TABLE_DENOMS  = 8;
    localparam int BASE_CAPACITY = 100;
    localparam int RECIP_SHIFT   = 18;

    // Action codes
    localparam logic [1:0] ACT_WITHDRAW = 2'd0;
    localparam logic [1:0] ACT_REFILL   = 2'd1;
    localparam logic [1:0] ACT_REPORT   = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OVER_BAL    = 3'd1;
    localparam logic [2:0] ST_NO_CHANGE   = 3'd2;
    localparam logic [2:0] ST_OVER_CAP    = 3'd3;
    localparam logic [2:0] ST_ZERO_IGNORE = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [17:0] amount;
        logic [2:0]  denom_sel;
        logic [13:0] refill_count;
    } t_in;

    typedef struct packed {
        logic [2:0]  denom_index;
        logic [13:0] notes_moved;
        logic [13:0] notes_left;
        logic [17:0] balance;
        logic [2:0]  status;
        logic        last;
    } t_out;

    function automatic logic [8:0] note_value(input logic [2:0] k);
        logic [8:0] v;
        case (k)
            3'd0:    v = 9'd500;
            3'd1:    v = 9'd150;
            3'd2:    v = 9'd50;
            3'd3:    v = 9'd20;
            3'd4:    v = 9'd10;
            3'd5:    v = 9'd5;
            3'd6:    v = 9'd2;
            default: v = 9'd1;
        endcase
        return v;
    endfunction

    // floor(2^18 / value): estimate is exact or one low for any 18-bit dividend
    function automatic logic [18:0] note_recip(input logic [2:0] k);
        logic [18:0] r;
        case (k)
            3'd0:    r = 19'd524;
            3'd1:    r = 19'd1747;
            3'd2:    r = 19'd5242;
            3'd3:    r = 19'd13107;
            3'd4:    r = 19'd26214;
            3'd5:    r = 19'd52428;
            3'd6:    r = 19'd131072;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] capacity(input logic [2:0] k);
        return 14'(BASE_CAPACITY) << k;
    endfunction

    function automatic int reset_balance(input int n);
        int sum;
        sum = 0;
        for (int k = 0; k < TABLE_DENOMS; k++) begin
            if (k < n) begin
                sum = sum + int'(capacity(3'(k))) * int'(note_value(3'(k)));
            end
        end
        return sum;
    endfunction

endpackage

>>> hdl/note_dispenser_with_inventory.sv
// Note dispenser core: greedy withdrawal over a bounded note stock, refill and report.
// Withdraw runs estimate, multiply and fix for each denomination in turn, then lists one
//   result per cycle for the N active denominations; no change or a refused or zero withdraw
//   gives one result; refill checks capacity, then adds notes; report lists the N stocks.
// One item at a time: busy is high while the item is worked on; the shared multiplier
//   sets the pace and the receiver cannot stall. Sync active-low reset fills the stock.
module note_dispenser_with_inventory #(
    parameter int NUM_DENOMS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ndisp_pkg::t_in    i_item,
    output logic              o_strobe,
    output ndisp_pkg::t_out   o_result
);

    // Only the eight known denominations exist.
    localparam int ACTIVE = (NUM_DENOMS < ndisp_pkg::TABLE_DENOMS) ?
                            NUM_DENOMS : ndisp_pkg::TABLE_DENOMS;
    localparam logic [2:0]  LAST_K  = 3'(ACTIVE - 1);
    localparam logic [17:0] RST_BAL = 18'(ndisp_pkg::reset_balance(ACTIVE));

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EST    = 3'd1;  // rem * recip -> quotient estimate
    localparam logic [2:0] S_MUL    = 3'd2;  // cap by stock, q * value
    localparam logic [2:0] S_FIX    = 3'd3;  // one-step correction, new remainder
    localparam logic [2:0] S_EMIT   = 3'd4;  // commit and list dispensed notes
    localparam logic [2:0] S_REFILL = 3'd5;  // capacity check
    localparam logic [2:0] S_RADD   = 3'd6;  // add notes and value
    localparam logic [2:0] S_REPORT = 3'd7;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_k, n_k;               // denomination being worked on
    logic [17:0] r_rem, n_rem;           // remainder of the greedy split
    logic [13:0] r_qc, n_qc;             // stock-capped quotient estimate
    logic [17:0] r_bal, n_bal;
    logic [17:0] r_amount, n_amount;
    logic [13:0] r_count, n_count;
    logic [36:0] r_prod, n_prod;         // shared multiplier output register
    logic [13:0] r_stock [ndisp_pkg::TABLE_DENOMS];
    logic [13:0] n_stock [ndisp_pkg::TABLE_DENOMS];
    logic [13:0] r_tent  [ndisp_pkg::TABLE_DENOMS];
    logic [13:0] n_tent  [ndisp_pkg::TABLE_DENOMS];
    logic            r_strobe, n_strobe;
    ndisp_pkg::t_out r_out, n_out;

    // Shared multiplier
    logic [18:0] mul_a;
    logic [17:0] mul_b;
    logic [36:0] mul_p;
    assign mul_p = {18'b0, mul_a} * {19'b0, mul_b};

    // Working values for the selected denomination
    logic [13:0] stock_k;
    logic [8:0]  value_k;
    logic [17:0] q_est;
    logic [13:0] q_cap;
    logic [17:0] r0;
    logic [13:0] q_fix;
    logic [17:0] rem_fix;
    logic [14:0] stock_sum;
    logic [13:0] left_k;

    assign stock_k   = r_stock[r_k];
    assign value_k   = ndisp_pkg::note_value(r_k);
    assign q_est     = r_prod[35:18];
    assign q_cap     = (q_est > {4'b0, stock_k}) ? stock_k : q_est[13:0];
    assign r0        = r_rem - r_prod[17:0];
    assign stock_sum = {1'b0, stock_k} + {1'b0, r_count};
    assign left_k    = stock_k - r_tent[r_k];

    // Estimate may be one short; bump it only while stock allows.
    always_comb begin
        if ((r_qc < stock_k) && (r0 >= {9'b0, value_k})) begin
            q_fix   = r_qc + 14'd1;
            rem_fix = r0 - {9'b0, value_k};
        end else begin
            q_fix   = r_qc;
            rem_fix = r0;
        end
    end

    function automatic ndisp_pkg::t_out make_out(
        input logic [2:0]  idx,
        input logic [13:0] moved,
        input logic [13:0] left,
        input logic [17:0] bal,
        input logic [2:0]  status,
        input logic        last
    );
        ndisp_pkg::t_out o;
        o.denom_index = idx;
        o.notes_moved = moved;
        o.notes_left  = left;
        o.balance     = bal;
        o.status      = status;
        o.last        = last;
        return o;
    endfunction

    always_comb begin
        n_state  = r_state;
        n_k      = r_k;
        n_rem    = r_rem;
        n_qc     = r_qc;
        n_bal    = r_bal;
        n_amount = r_amount;
        n_count  = r_count;
        n_prod   = r_prod;
        n_stock  = r_stock;
        n_tent   = r_tent;
        n_strobe = 1'b0;
        n_out    = r_out;
        mul_a    = '0;
        mul_b    = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_amount = i_item.amount;
                    n_count  = i_item.refill_count;
                    case (i_item.action)
                        ndisp_pkg::ACT_WITHDRAW: begin
                            if (i_item.amount == 18'd0) begin
                                n_strobe = 1'b1;
                                n_out    = make_out(3'd0, 14'd0, 14'd0, r_bal,
                                                    ndisp_pkg::ST_ZERO_IGNORE, 1'b1);
                            end else if (i_item.amount > r_bal) begin
                                n_strobe = 1'b1;
                                n_out    = make_out(3'd0, 14'd0, 14'd0, r_bal,
                                                    ndisp_pkg::ST_OVER_BAL, 1'b1);
                            end else begin
                                n_rem   = i_item.amount;
                                n_k     = 3'd0;
                                n_state = S_EST;
                            end
                        end
                        ndisp_pkg::ACT_REFILL: begin
                            n_k     = i_item.denom_sel;
                            n_state = S_REFILL;
                        end
                        ndisp_pkg::ACT_REPORT: begin
                            n_k     = 3'd0;
                            n_state = S_REPORT;
                        end
                        default: begin
                            // unused action code: no result
                        end
                    endcase
                end
            end
            S_EST: begin
                mul_a   = ndisp_pkg::note_recip(r_k);
                mul_b   = r_rem;
                n_prod  = mul_p;
                n_state = S_MUL;
            end
            S_MUL: begin
                mul_a   = {5'b0, q_cap};
                mul_b   = {9'b0, value_k};
                n_prod  = mul_p;
                n_qc    = q_cap;
                n_state = S_FIX;
            end
            S_FIX: begin
                n_tent[r_k] = q_fix;
                n_rem       = rem_fix;
                if (r_k == LAST_K) begin
                    if (rem_fix != 18'd0) begin
                        // stock untouched so far, nothing to roll back
                        n_strobe = 1'b1;
                        n_out    = make_out(3'd0, 14'd0, 14'd0, r_bal,
                                            ndisp_pkg::ST_NO_CHANGE, 1'b1);
                        n_state  = S_IDLE;
                    end else begin
                        n_bal   = r_bal - r_amount;
                        n_k     = 3'd0;
                        n_state = S_EMIT;
                    end
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_EST;
                end
            end
            S_EMIT: begin
                n_stock[r_k] = left_k;
                n_strobe     = 1'b1;
                n_out        = make_out(r_k, r_tent[r_k], left_k, r_bal,
                                        ndisp_pkg::ST_OK, r_k == LAST_K);
                if (r_k == LAST_K) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_REFILL: begin
                if (int'(r_k) >= ACTIVE) begin
                    n_strobe = 1'b1;
                    n_out    = make_out(r_k, 14'd0, 14'd0, r_bal,
                                        ndisp_pkg::ST_OVER_CAP, 1'b1);
                    n_state  = S_IDLE;
                end else if (stock_sum > {1'b0, ndisp_pkg::capacity(r_k)}) begin
                    n_strobe = 1'b1;
                    n_out    = make_out(r_k, 14'd0, stock_k, r_bal,
                                        ndisp_pkg::ST_OVER_CAP, 1'b1);
                    n_state  = S_IDLE;
                end else begin
                    mul_a   = {5'b0, r_count};
                    mul_b   = {9'b0, value_k};
                    n_prod  = mul_p;
                    n_state = S_RADD;
                end
            end
            S_RADD: begin
                n_stock[r_k] = stock_sum[13:0];
                n_bal        = r_bal + r_prod[17:0];
                n_strobe     = 1'b1;
                n_out        = make_out(r_k, r_count, stock_sum[13:0],
                                        r_bal + r_prod[17:0], ndisp_pkg::ST_OK, 1'b1);
                n_state      = S_IDLE;
            end
            S_REPORT: begin
                n_strobe = 1'b1;
                n_out    = make_out(r_k, 14'd0, stock_k, r_bal,
                                    ndisp_pkg::ST_OK, r_k == LAST_K);
                if (r_k == LAST_K) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and inventory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_bal    <= RST_BAL;
            for (int k = 0; k < ndisp_pkg::TABLE_DENOMS; k++) begin
                r_stock[k] <= (k < ACTIVE) ? ndisp_pkg::capacity(3'(k)) : 14'd0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_bal    <= n_bal;
            r_stock  <= n_stock;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_rem    <= n_rem;
        r_qc     <= n_qc;
        r_amount <= n_amount;
        r_count  <= n_count;
        r_prod   <= n_prod;
        r_tent   <= n_tent;
        r_out    <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule
